[src/eidpt_pkg.sv]
// ---------------------------------------------------------------------------
// Entity ID allocator package
// Shared widths, request and status codes, and the control and status
// structs that pass between the allocator top level and its ID pool.
// ---------------------------------------------------------------------------
package eidpt_pkg;

    // Field widths of a request and of a result.
    localparam int ID_W     = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Size of the identifier space that the 8-bit fields can name.
    localparam int ID_SPACE = 1 << ID_W;

    // Default number of entities, including the root.
    localparam int DEFAULT_MAX_ENTITIES = 256;

    // Request kinds.
    typedef enum logic [OP_W-1:0] {
        OP_CREATE     = 2'd0,
        OP_REMOVE     = 2'd1,
        OP_GET_PARENT = 2'd2,
        OP_CHECK      = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    // Commands from the request stage to the ID pool, applied on commit.
    typedef struct packed {
        logic            take;     // hand out the next free identifier
        logic            push;     // return an identifier to the free stack
        logic [ID_W-1:0] push_id;  // identifier being returned
    } pool_ctrl_t;

    // What the ID pool offers to the request in the input register.
    typedef struct packed {
        logic            avail;    // an identifier can be issued
        logic [ID_W-1:0] next_id;  // identifier that a create would get
    } pool_stat_t;

endpackage

[src/eidpt_idpool.sv]
// ---------------------------------------------------------------------------
// Entity ID pool
// LIFO stack of freed identifiers plus a rising counter for fresh ones.
// The stack top is read from memory when a request is accepted, so that
// the next identifier is ready when that request executes.
// ---------------------------------------------------------------------------
module eidpt_idpool #(
    parameter int MAX_ENTITIES = eidpt_pkg::DEFAULT_MAX_ENTITIES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  eidpt_pkg::pool_ctrl_t  ctrl,
    output eidpt_pkg::pool_stat_t  stat
);
    import eidpt_pkg::*;

    localparam int DEPTH = (MAX_ENTITIES > ID_SPACE) ? ID_SPACE : MAX_ENTITIES;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(DEPTH - 1);

    logic [ID_W-1:0]  stack_mem [DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ID_W-1:0]  last_reg, last_next;
    logic [ID_W-1:0]  rd_reg;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             stack_nonempty;

    assign stack_nonempty = (cnt_reg != '0);
    assign wr_addr        = cnt_reg[IDX_W-1:0];

    // Identifier offered to a create: stack top first, then the counter.
    always_comb
    begin
        stat.avail   = stack_nonempty || (last_reg < ID_LIMIT);
        stat.next_id = stack_nonempty ? rd_reg : last_reg + ID_W'(1);
    end

    // Pool state after the committing request, if any.
    always_comb
    begin
        cnt_next  = cnt_reg;
        last_next = last_reg;
        priority if (ctrl.push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (ctrl.take)
        begin
            if (stack_nonempty)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
            else
            begin
                last_next = last_reg + ID_W'(1);
            end
        end
    end

    // The next stack top, as seen after this cycle's commit.
    assign rd_addr = IDX_W'(cnt_next - CNT_W'(1));

    // Count and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    // Stack memory with registered read; a push to the address being read
    // in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            stack_mem[wr_addr] <= ctrl.push_id;
        end
        if (load)
        begin
            if (ctrl.push && (wr_addr == rd_addr))
            begin
                rd_reg <= ctrl.push_id;
            end
            else
            begin
                rd_reg <= stack_mem[rd_addr];
            end
        end
    end

endmodule

[src/entity_id_allocator_parent_table.sv]
// ---------------------------------------------------------------------------
// Entity ID allocator with parent table
// Issues entity identifiers, records their parents, and answers removal,
// parent and membership queries.
// ---------------------------------------------------------------------------
// A request (create, remove, get parent, check valid) is taken into an input
// register, and its result is then written into the output register when the
// request commits to it, and one request is accepted every cycle while
// the result side keeps up. The table memories (free stack and parent table)
// are read once per request at the moment it is accepted, and the state
// update of the request ahead is forwarded into that read. Created
// identifiers come first from the most recently removed ones and then from a
// counter running from 1 up to the smaller of MAX_ENTITIES-1 and 255;
// identifier 0 is the root and is never issued. Present marks are cleared
// by reset at once, so requests are accepted from the first cycle after
// reset. Removing an absent identifier is refused with not-found status.
// ---------------------------------------------------------------------------
module entity_id_allocator_parent_table #(
    parameter int MAX_ENTITIES = eidpt_pkg::DEFAULT_MAX_ENTITIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [eidpt_pkg::OP_W-1:0]       op,
    input  logic [eidpt_pkg::ID_W-1:0]       entity,
    input  logic [eidpt_pkg::ID_W-1:0]       parent,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [eidpt_pkg::ID_W-1:0]       result_id,
    output logic                             is_valid,
    output logic [eidpt_pkg::STATUS_W-1:0]   status
);
    import eidpt_pkg::*;

    localparam int DEPTH = (MAX_ENTITIES > ID_SPACE) ? ID_SPACE : MAX_ENTITIES;
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [ID_W:0] DEPTH_V = (ID_W + 1)'(DEPTH);

    // Input register.
    logic             req_full_reg;
    op_t              op_reg;
    logic [ID_W-1:0]  entity_reg;
    logic [ID_W-1:0]  parent_reg;

    // Output register.
    logic             rsp_valid_reg;
    logic [ID_W-1:0]  result_id_reg;
    logic             is_valid_reg;
    status_t          status_reg;

    // Tables.
    logic [DEPTH-1:0] present_reg;
    logic [ID_W-1:0]  parent_mem [DEPTH];
    logic [ID_W-1:0]  parent_rd_reg;

    logic             commit;
    logic             accept;
    logic             ent_in_range;
    logic [IDX_W-1:0] ent_idx;
    logic             ent_present;
    logic [IDX_W-1:0] new_idx;
    logic [IDX_W-1:0] port_idx;
    logic             create_ok;
    logic             remove_ok;
    logic [ID_W-1:0]  rid;
    logic             vld;
    status_t          st;
    pool_ctrl_t       pool_ctrl;
    pool_stat_t       pool_stat;

    // Handshake: the request moves on whenever the output register is free.
    assign commit    = req_full_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_full_reg && !commit;
    assign accept    = req_valid && !req_stall;

    // Free stack and counter.
    eidpt_idpool #(
        .MAX_ENTITIES (MAX_ENTITIES)
    ) u_idpool (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .ctrl  (pool_ctrl),
        .stat  (pool_stat)
    );

    // Lookup of the entity held in the input register.
    assign ent_in_range = ({1'b0, entity_reg} < DEPTH_V);
    assign ent_idx      = entity_reg[IDX_W-1:0];
    assign ent_present  = ent_in_range && present_reg[ent_idx];
    assign new_idx      = pool_stat.next_id[IDX_W-1:0];
    assign port_idx     = entity[IDX_W-1:0];

    // Execute the request in the input register.
    always_comb
    begin
        create_ok = 1'b0;
        remove_ok = 1'b0;
        rid       = '0;
        vld       = 1'b0;
        st        = STATUS_OK;
        unique case (op_reg)
            OP_CREATE:
            begin
                if (pool_stat.avail)
                begin
                    create_ok = 1'b1;
                    rid       = pool_stat.next_id;
                end
                else
                begin
                    st = STATUS_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (ent_present)
                begin
                    remove_ok = 1'b1;
                    vld       = 1'b1;
                end
                else
                begin
                    st = STATUS_NOT_FOUND;
                end
            end
            OP_GET_PARENT:
            begin
                if (ent_present)
                begin
                    rid = parent_rd_reg;
                    vld = 1'b1;
                end
            end
            OP_CHECK:
            begin
                vld = ent_present;
            end
            default:
            begin
                st = STATUS_OK;
            end
        endcase
    end

    // Pool commands take effect only when the request commits.
    always_comb
    begin
        pool_ctrl.take    = commit && create_ok;
        pool_ctrl.push    = commit && remove_ok;
        pool_ctrl.push_id = entity_reg;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_full_reg <= 1'b0;
        end
        else if (accept)
        begin
            req_full_reg <= 1'b1;
        end
        else if (commit)
        begin
            req_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op_t'(op);
            entity_reg <= entity;
            parent_reg <= parent;
        end
    end

    // Present marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else
        begin
            if (commit && create_ok)
            begin
                present_reg[new_idx] <= 1'b1;
            end
            if (commit && remove_ok)
            begin
                present_reg[ent_idx] <= 1'b0;
            end
        end
    end

    // Parent table with registered read at accept; a parent written by the
    // committing create to the same identifier is forwarded.
    always_ff @(posedge clk)
    begin
        if (commit && create_ok)
        begin
            parent_mem[new_idx] <= parent_reg;
        end
        if (accept)
        begin
            if (commit && create_ok && (new_idx == port_idx))
            begin
                parent_rd_reg <= parent_reg;
            end
            else
            begin
                parent_rd_reg <= parent_mem[port_idx];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            result_id_reg <= rid;
            is_valid_reg  <= vld;
            status_reg    <= st;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign result_id = result_id_reg;
    assign is_valid  = is_valid_reg;
    assign status    = status_reg;

endmodule
